[sv/tbtw_pkg.sv]
// ----------------------------------------------------------------------------
// tbtw_pkg
// Shared types, constants and helpers of the trigger time and width extractor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tbtw_pkg;

    // Record word and result widths
    localparam int WORD_W   = 64;
    localparam int SUM_W    = 11;
    localparam int CFG_W    = 8;
    localparam int CFG_IDX_W = 1;

    // Block header separator in the upper half of the word
    localparam logic [31:0] SEPARATOR = 32'hcafecafe;

    // Saturation value of the time and width sums
    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCINT_BLOCK_INDEX = 1'd1;

    // Reset values of the configuration registers
    localparam logic [CFG_W-1:0] LIMIT_RESET = 8'd1;
    localparam logic [CFG_W-1:0] SCINT_RESET = 8'd0;

    // Walk phase of one event record
    typedef enum logic [4:0] {
        PH_HEADER    = 5'b00001,
        PH_BLOCK_HDR = 5'b00010,
        PH_SKIP      = 5'b00100,
        PH_SCAN      = 5'b01000,
        PH_DONE      = 5'b10000
    } t_phase;

    // Add two sums and clamp at the top of the range
    function automatic logic [SUM_W-1:0] sat_add(
        input logic [SUM_W-1:0] a,
        input logic [SUM_W-1:0] b
    );
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
    endfunction

endpackage

`default_nettype wire

[sv/trigger_block_time_width_extract.sv]
// ----------------------------------------------------------------------------
// trigger_block_time_width_extract
// Walks the blocks of one event record and measures the trigger time and
// pulse width from the sampled words of the scintillator block.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                   Payload
//  in        request    i_in_valid / o_in_ready     data_word, first_word, last_word
//  out       result     o_out_valid / i_out_ready   trig_time, trig_width,
//                                                   scint_found, corrupt
//  cfg       write      i_cfg_we                    i_cfg_index, i_cfg_data
//
//  One request per cycle is taken unless a last_word request is held; a
//  request lands in the input register and its state update and result are
//  formed by one level of logic into the state and result registers.
//  The critical path is the 32-bit leading-count and saturating add.
//  A request carrying last_word waits in the input register only while the
//  result register is full and not being taken. Reset is synchronous and
//  puts the block at the start of an event with no result pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trigger_block_time_width_extract #(
    parameter int HEADER_WORDS = 3,
    parameter int WORDS_PER_BX = 7,
    parameter int TRIG_BITS    = 32
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // request channel
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [tbtw_pkg::WORD_W-1:0]     i_data_word,
    input  wire logic                            i_first_word,
    input  wire logic                            i_last_word,
    // result channel
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic      [tbtw_pkg::SUM_W-1:0]      o_trig_time,
    output logic      [tbtw_pkg::SUM_W-1:0]      o_trig_width,
    output logic                                 o_scint_found,
    output logic                                 o_corrupt,
    // configuration writes
    input  wire logic                            i_cfg_we,
    input  wire logic [tbtw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [tbtw_pkg::CFG_W-1:0]      i_cfg_data
);

    localparam int HDR_W = $clog2(HEADER_WORDS + 1);
    localparam int BX_W  = (WORDS_PER_BX > 1) ? $clog2(WORDS_PER_BX) : 1;
    localparam int CNT_W = $clog2(TRIG_BITS + 1);
    localparam int SUM_W = tbtw_pkg::SUM_W;

    // Configuration
    logic [tbtw_pkg::CFG_W-1:0] r_limit;
    logic [tbtw_pkg::CFG_W-1:0] r_scint_idx;

    // Input register
    logic                        r_in_valid;
    logic [tbtw_pkg::WORD_W-1:0] r_word;
    logic                        r_first;
    logic                        r_last;

    // Walk state
    tbtw_pkg::t_phase r_phase, n_phase;
    logic [HDR_W-1:0] r_hdr, n_hdr;
    logic [7:0]       r_blk, n_blk;
    logic [7:0]       r_len, n_len;
    logic [7:0]       r_off, n_off;
    logic [BX_W-1:0]  r_bx, n_bx;
    logic             r_fired, n_fired;
    logic [SUM_W-1:0] r_time, n_time;
    logic [SUM_W-1:0] r_width, n_width;
    logic             r_err, n_err;
    logic             r_scint, n_scint;

    // Result register
    logic             r_out_valid;
    logic [SUM_W-1:0] r_res_time;
    logic [SUM_W-1:0] r_res_width;
    logic             r_res_scint;
    logic             r_res_err;

    // Stage control and sample counts
    logic                 adv;
    logic [TRIG_BITS-1:0] bits;
    logic [TRIG_BITS-1:0] inv;
    logic [TRIG_BITS-1:0] inv_rev;
    logic [CNT_W-1:0]     lead_zeros;
    logic [CNT_W-1:0]     lead_ones;
    logic [CNT_W-1:0]     trail_ones;

    // Move the held request on unless it is a last word facing a full result register that is not being taken
    assign adv        = r_in_valid && (!r_last || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= tbtw_pkg::LIMIT_RESET;
            r_scint_idx <= tbtw_pkg::SCINT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tbtw_pkg::CFG_BLOCK_COUNT_LIMIT: r_limit     <= i_cfg_data;
                tbtw_pkg::CFG_SCINT_BLOCK_INDEX: r_scint_idx <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Capture requests
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_word  <= i_data_word;
            r_first <= i_first_word;
            r_last  <= i_last_word;
        end
    end

    // Trigger bits and their counts
    assign bits = r_word[TRIG_BITS-1:0];
    assign inv  = ~bits;

    always_comb begin
        for (int i = 0; i < TRIG_BITS; i++) begin
            inv_rev[i] = inv[TRIG_BITS-1-i];
        end
    end

    tbtw_lzc #(.W(TRIG_BITS)) u_lz_bits (.i_vec(bits),    .o_count(lead_zeros));
    tbtw_lzc #(.W(TRIG_BITS)) u_lo_bits (.i_vec(inv),     .o_count(lead_ones));
    tbtw_lzc #(.W(TRIG_BITS)) u_to_bits (.i_vec(inv_rev), .o_count(trail_ones));

    // Next walk state for the held word
    always_comb begin
        logic [HDR_W-1:0] hdr_inc;
        logic [7:0]       off_inc;

        // start from the event start values on a first word
        if (r_first) begin
            n_phase = tbtw_pkg::PH_HEADER;
            n_hdr   = '0;
            n_blk   = '0;
            n_len   = '0;
            n_off   = '0;
            n_bx    = '0;
            n_fired = 1'b0;
            n_time  = '0;
            n_width = '0;
            n_err   = 1'b0;
            n_scint = 1'b0;
        end else begin
            n_phase = r_phase;
            n_hdr   = r_hdr;
            n_blk   = r_blk;
            n_len   = r_len;
            n_off   = r_off;
            n_bx    = r_bx;
            n_fired = r_fired;
            n_time  = r_time;
            n_width = r_width;
            n_err   = r_err;
            n_scint = r_scint;
        end

        hdr_inc = n_hdr + HDR_W'(1);
        off_inc = n_off + 8'd1;

        unique case (n_phase)
            tbtw_pkg::PH_HEADER: begin
                n_hdr = hdr_inc;
                if (hdr_inc >= HDR_W'(HEADER_WORDS)) begin
                    n_phase = tbtw_pkg::PH_BLOCK_HDR;
                end
            end
            tbtw_pkg::PH_BLOCK_HDR: begin
                if (n_blk >= r_limit) begin
                    n_phase = tbtw_pkg::PH_DONE;
                end else if (r_word[63:32] != tbtw_pkg::SEPARATOR) begin
                    n_err   = 1'b1;
                    n_phase = tbtw_pkg::PH_DONE;
                end else begin
                    n_len = r_word[7:0];
                    n_off = '0;
                    n_bx  = '0;
                    if (n_blk == r_scint_idx) begin
                        n_scint = 1'b1;
                        n_phase = (r_word[7:0] == 8'd0) ? tbtw_pkg::PH_DONE
                                                        : tbtw_pkg::PH_SCAN;
                    end else if (r_word[7:0] == 8'd0) begin
                        n_blk = n_blk + 8'd1;
                    end else begin
                        n_phase = tbtw_pkg::PH_SKIP;
                    end
                end
            end
            tbtw_pkg::PH_SKIP: begin
                n_off = off_inc;
                if (off_inc >= n_len) begin
                    n_blk   = n_blk + 8'd1;
                    n_phase = tbtw_pkg::PH_BLOCK_HDR;
                end
            end
            tbtw_pkg::PH_SCAN: begin
                n_off = off_inc;
                // sample the last word of each bunch crossing
                if (n_bx == BX_W'(WORDS_PER_BX - 1)) begin
                    n_bx = '0;
                    if (!n_fired) begin
                        n_time = tbtw_pkg::sat_add(n_time, SUM_W'(lead_zeros));
                        if (bits != '0) begin
                            n_fired = 1'b1;
                            n_width = tbtw_pkg::sat_add(n_width, SUM_W'(trail_ones));
                        end
                    end else if (bits != '0) begin
                        n_width = tbtw_pkg::sat_add(n_width, SUM_W'(lead_ones));
                    end else begin
                        n_phase = tbtw_pkg::PH_DONE;
                    end
                end else begin
                    n_bx = n_bx + BX_W'(1);
                end
                if (off_inc >= n_len) begin
                    n_phase = tbtw_pkg::PH_DONE;
                end
            end
            tbtw_pkg::PH_DONE: ;
            default: n_phase = tbtw_pkg::PH_DONE;
        endcase
    end

    // Advance walk state; return to event start after the last word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (adv && r_last)) begin
            r_phase <= tbtw_pkg::PH_HEADER;
            r_hdr   <= '0;
            r_blk   <= '0;
            r_len   <= '0;
            r_off   <= '0;
            r_bx    <= '0;
            r_fired <= 1'b0;
            r_time  <= '0;
            r_width <= '0;
            r_err   <= 1'b0;
            r_scint <= 1'b0;
        end else if (adv) begin
            r_phase <= n_phase;
            r_hdr   <= n_hdr;
            r_blk   <= n_blk;
            r_len   <= n_len;
            r_off   <= n_off;
            r_bx    <= n_bx;
            r_fired <= n_fired;
            r_time  <= n_time;
            r_width <= n_width;
            r_err   <= n_err;
            r_scint <= n_scint;
        end
    end

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_last) begin
            r_res_time  <= n_time;
            r_res_width <= n_width;
            r_res_scint <= n_scint;
            r_res_err   <= n_err;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_trig_time   = r_res_time;
    assign o_trig_width  = r_res_width;
    assign o_scint_found = r_res_scint;
    assign o_corrupt     = r_res_err;

endmodule

`default_nettype wire

[sv/tbtw_lzc.sv]
// ----------------------------------------------------------------------------
// tbtw_lzc
// Leading zero count of a vector; an all-zero vector counts its full width.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tbtw_lzc #(
    parameter int W = 32
) (
    input  wire logic [W-1:0]           i_vec,
    output logic      [$clog2(W+1)-1:0] o_count
);

    localparam int CNT_W = $clog2(W + 1);

    logic [CNT_W-1:0] cnt;

    // Encode the position of the highest one; later bits take priority
    always_comb begin
        cnt = CNT_W'(W);
        for (int i = 0; i < W; i++) begin
            if (i_vec[i]) begin
                cnt = CNT_W'(W - 1 - i);
            end
        end
    end

    assign o_count = cnt;

endmodule

`default_nettype wire

[sv/tbtw_checker.sv]
// ----------------------------------------------------------------------------
// tbtw_checker
// Port-level checks of the trigger time and width extractor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tbtw_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            o_in_ready,
    input wire logic                            o_out_valid,
    input wire logic                            i_out_ready,
    input wire logic [tbtw_pkg::SUM_W-1:0]      o_trig_time,
    input wire logic [tbtw_pkg::SUM_W-1:0]      o_trig_width,
    input wire logic                            o_scint_found,
    input wire logic                            o_corrupt
);

    // A waiting result keeps its value until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_trig_time)
            && $stable(o_trig_width) && $stable(o_scint_found) && $stable(o_corrupt))
        else $error("result changed while stalled");

    // An empty result register never blocks requests
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("request stalled with result register empty");

    // Time and width only grow inside the scintillator block
    a_sums_need_scint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_scint_found |-> o_trig_time == '0 && o_trig_width == '0)
        else $error("sums without scintillator block");

    // A bad separator ends the walk before the scintillator block
    a_corrupt_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_corrupt |-> !o_scint_found)
        else $error("corrupt and scintillator block both flagged");

    // No result directly after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind trigger_block_time_width_extract tbtw_checker u_tbtw_checker (.*);

`default_nettype wire

[tb/sv/trigger_block_time_width_extract_test.sv]
// ----------------------------------------------------------------------------
// trigger_block_time_width_extract_test
// Streams event records through the trigger time and width extractor under
// several block limit and scintillator index settings. A word-level walker
// built into the bench predicts each result, and every result the block hands
// out is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trigger_block_time_width_extract_test;

    import tbtw_pkg::*;

    localparam int HDR_WORDS   = 3;
    localparam int BX_WORDS    = 7;
    localparam int TRIG_W      = 32;
    localparam int TAIL_CYCLES = 8;

    typedef struct packed {
        logic [WORD_W-1:0] data;
        logic              is_first;
        logic              is_last;
    } word_req_t;

    typedef struct packed {
        logic [SUM_W-1:0] zero_count;
        logic [SUM_W-1:0] pulse_count;
        logic             scint_hit;
        logic             bad_sep;
    } event_result_t;

    // Block ports
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [WORD_W-1:0]    i_data_word = '0;
    logic                 i_first_word = 1'b0;
    logic                 i_last_word = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [SUM_W-1:0]     o_trig_time;
    logic [SUM_W-1:0]     o_trig_width;
    logic                 o_scint_found;
    logic                 o_corrupt;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    // Request and result stores
    word_req_t     pending_words[$];
    event_result_t want_results[$];
    int            queued_words = 0;
    int            results_seen = 0;
    int            mismatch_count = 0;

    // Walker state and its copy of the registers
    logic [CFG_W-1:0] cfg_limit = LIMIT_RESET;
    logic [CFG_W-1:0] cfg_scint = SCINT_RESET;
    t_phase           walk_phase;
    int               hdr_count;
    int               blk_num;
    int               blk_len;
    int               blk_off;
    logic             fired;
    logic [SUM_W-1:0] zero_sum;
    logic [SUM_W-1:0] pulse_sum;
    logic             bad_sep_seen;
    logic             scint_seen;

    // Idle pacing and the one long receiver hold-off
    int   cycle_count = 0;
    logic calm;
    int   hold_left = 0;
    bit   hold_done = 0;

    assign calm = (cycle_count >= 3000) && (cycle_count < 4500);

    trigger_block_time_width_extract u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_data_word   (i_data_word),
        .i_first_word  (i_first_word),
        .i_last_word   (i_last_word),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_trig_time   (o_trig_time),
        .o_trig_width  (o_trig_width),
        .o_scint_found (o_scint_found),
        .o_corrupt     (o_corrupt),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Zeros above the highest set bit of one trigger sample
    function automatic int lead_zeros(input logic [TRIG_W-1:0] v);
        for (int i = TRIG_W - 1; i >= 0; i--) begin
            if (v[i]) return TRIG_W - 1 - i;
        end
        return TRIG_W;
    endfunction

    function automatic logic [SUM_W-1:0] clamp_sum(input int s);
        return (s > int'(SUM_MAX)) ? SUM_MAX : s[SUM_W-1:0];
    endfunction

    task automatic restart_walk();
        walk_phase   = PH_HEADER;
        hdr_count    = 0;
        blk_num      = 0;
        blk_len      = 0;
        blk_off      = 0;
        fired        = 1'b0;
        zero_sum     = '0;
        pulse_sum    = '0;
        bad_sep_seen = 1'b0;
        scint_seen   = 1'b0;
    endtask

    // Advance the walker by one accepted request; queue a result on last_word
    task automatic advance_walk(input word_req_t req);
        logic [TRIG_W-1:0] bits;
        logic [TRIG_W-1:0] flipped;
        event_result_t     res;
        bits = req.data[TRIG_W-1:0];
        if (req.is_first) restart_walk();
        case (walk_phase)
            PH_HEADER: begin
                hdr_count++;
                if (hdr_count >= HDR_WORDS) walk_phase = PH_BLOCK_HDR;
            end
            PH_BLOCK_HDR: begin
                if (blk_num >= cfg_limit) begin
                    walk_phase = PH_DONE;
                end else if (req.data[63:32] != SEPARATOR) begin
                    bad_sep_seen = 1'b1;
                    walk_phase   = PH_DONE;
                end else begin
                    blk_len = req.data[7:0];
                    blk_off = 0;
                    if (blk_num == cfg_scint) begin
                        scint_seen = 1'b1;
                        walk_phase = (blk_len == 0) ? PH_DONE : PH_SCAN;
                    end else if (blk_len == 0) begin
                        blk_num++;
                    end else begin
                        walk_phase = PH_SKIP;
                    end
                end
            end
            PH_SKIP: begin
                blk_off++;
                if (blk_off >= blk_len) begin
                    blk_num++;
                    walk_phase = PH_BLOCK_HDR;
                end
            end
            PH_SCAN: begin
                blk_off++;
                if (blk_off % BX_WORDS == 0) begin
                    if (!fired) begin
                        zero_sum = clamp_sum(zero_sum + lead_zeros(bits));
                        if (bits != '0) begin
                            // trailing ones counted as leading zeros of the
                            // bit-reversed complement
                            fired   = 1'b1;
                            flipped = {<<{~bits}};
                            pulse_sum = clamp_sum(pulse_sum + lead_zeros(flipped));
                        end
                    end else if (bits != '0) begin
                        pulse_sum = clamp_sum(pulse_sum + lead_zeros(~bits));
                    end else begin
                        walk_phase = PH_DONE;
                    end
                end
                if (blk_off >= blk_len) walk_phase = PH_DONE;
            end
            default: ;
        endcase
        if (req.is_last) begin
            res = '{zero_count: zero_sum, pulse_count: pulse_sum,
                    scint_hit: scint_seen, bad_sep: bad_sep_seen};
            want_results.push_back(res);
            restart_walk();
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("ERROR @%0t %s: got %0d, want %0d", $time, what, got, want);
    endtask

    // Request driver: hold while stalled, otherwise offer the next word or idle
    always @(posedge i_clk) begin : drive_requests
        word_req_t req;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                advance_walk('{data: i_data_word, is_first: i_first_word,
                               is_last: i_last_word});
            if (i_in_valid && !o_in_ready) begin
                // hold the offered request
            end else if (pending_words.size() > 0 &&
                         (calm || $urandom_range(0, 99) >= 16)) begin
                req = pending_words.pop_front();
                i_in_valid   <= 1'b1;
                i_data_word  <= req.data;
                i_first_word <= req.is_first;
                i_last_word  <= req.is_last;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result ready: random stalls plus one long hold-off while requests pile up
    always @(posedge i_clk) begin : drive_ready
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (!hold_done && results_seen >= 3 && pending_words.size() >= 200) begin
            hold_done = 1;
            hold_left = 400;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= calm || ($urandom_range(0, 99) >= 16);
        end
    end

    // Result checker
    always @(posedge i_clk) begin : check_results
        event_result_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (want_results.size() == 0) begin
                report_mismatch("result with nothing expected", o_trig_time, 0);
            end else begin
                want = want_results.pop_front();
                if (o_trig_time !== want.zero_count)
                    report_mismatch("trig_time", o_trig_time, want.zero_count);
                if (o_trig_width !== want.pulse_count)
                    report_mismatch("trig_width", o_trig_width, want.pulse_count);
                if (o_scint_found !== want.scint_hit)
                    report_mismatch("scint_found", o_scint_found, want.scint_hit);
                if (o_corrupt !== want.bad_sep)
                    report_mismatch("corrupt", o_corrupt, want.bad_sep);
            end
        end
    end

    task automatic push_word(input logic [WORD_W-1:0] data, input logic is_first,
                             input logic is_last);
        pending_words.push_back('{data: data, is_first: is_first, is_last: is_last});
        queued_words++;
    endtask

    // Random words with random start and end marks
    task automatic queue_noise(input int n);
        logic [WORD_W-1:0] w;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 5))
                0:       w = '0;
                1:       w = '1;
                2:       w = {SEPARATOR, $urandom()};
                default: w = {$urandom(), $urandom()};
            endcase
            push_word(w, $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
        end
    endtask

    // One event record: header words, n_before blocks, a scan block, up to two trailing words, optionally cut short
    task automatic queue_event(input int n_before, input bit use_first,
                               input bit bad_header, input bit cut_short);
        word_req_t         rec[$];
        int                bad_at;
        int                blen;
        int                n_bx;
        int                mode;
        int                start;
        int                plen;
        int                pos;
        int                cut;
        logic [31:0]       upper;
        logic [TRIG_W-1:0] bits;
        logic [WORD_W-1:0] w;
        for (int k = 0; k < HDR_WORDS; k++)
            rec.push_back('{data: {$urandom(), $urandom()},
                            is_first: use_first && k == 0, is_last: 1'b0});
        bad_at = bad_header ? $urandom_range(0, n_before) : -1;
        for (int b = 0; b <= n_before; b++) begin
            upper = (b == bad_at) ? (SEPARATOR ^ ($urandom() | 32'h1)) : SEPARATOR;
            if (b < n_before) begin
                blen = (n_before > 6 && $urandom_range(0, 7) != 0) ? 0
                                                                    : $urandom_range(0, 6);
            end else begin
                case ($urandom_range(0, 19))
                    0:       blen = $urandom_range(240, 255);
                    1:       blen = 0;
                    default: blen = $urandom_range(1, 35);
                endcase
            end
            rec.push_back('{data: {upper, 24'($urandom()), 8'(blen)},
                            is_first: 1'b0, is_last: 1'b0});
            n_bx  = blen / BX_WORDS;
            mode  = $urandom_range(0, 4);
            start = $urandom_range(0, n_bx * TRIG_W);
            plen  = $urandom_range(1, 80);
            for (int off = 1; off <= blen; off++) begin
                w = {$urandom(), $urandom()};
                // scan block: shape the sampled words, in one mode as one trigger pulse
                if (b == n_before && off % BX_WORDS == 0) begin
                    case (mode)
                        0: begin
                            for (int j = 0; j < TRIG_W; j++) begin
                                pos = (off / BX_WORDS - 1) * TRIG_W + TRIG_W - 1 - j;
                                bits[j] = (pos >= start) && (pos < start + plen);
                            end
                        end
                        1:       bits = $urandom() & $urandom() & $urandom();
                        2:       bits = '0;
                        3:       bits = '1;
                        default: bits = $urandom();
                    endcase
                    w[TRIG_W-1:0] = bits;
                end
                rec.push_back('{data: w, is_first: 1'b0, is_last: 1'b0});
            end
        end
        repeat ($urandom_range(0, 2))
            rec.push_back('{data: {$urandom(), $urandom()}, is_first: 1'b0, is_last: 1'b0});
        if (cut_short) begin
            cut = $urandom_range(1, rec.size());
            while (rec.size() > cut) void'(rec.pop_back());
        end
        rec[rec.size() - 1].is_last = 1'b1;
        foreach (rec[k]) push_word(rec[k].data, rec[k].is_first, rec[k].is_last);
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || i_in_valid || want_results.size() != 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        if (idx == CFG_BLOCK_COUNT_LIMIT) cfg_limit = val;
        else cfg_scint = val;
        @(posedge i_clk);
    endtask

    // One register setting: drain and write if asked, then a burst of records and noise
    task automatic run_setting(input bit do_write, input logic [CFG_W-1:0] limit_val,
                               input logic [CFG_W-1:0] scint_val, input int words_wanted);
        int start_words;
        int pick;
        int n_before;
        int reach;
        bit open_event;
        if (do_write) begin
            wait_drained();
            write_reg(CFG_BLOCK_COUNT_LIMIT, limit_val);
            write_reg(CFG_SCINT_BLOCK_INDEX, scint_val);
            i_cfg_we <= 1'b0;
        end
        start_words = queued_words;
        open_event  = 0;
        while (queued_words - start_words < words_wanted || open_event) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                queue_noise($urandom_range(3, 12));
                open_event = 1;
            end else begin
                reach    = (cfg_scint + 3 > 12) ? 12 : cfg_scint + 3;
                n_before = ($urandom_range(0, 9) < 7) ? cfg_scint : $urandom_range(0, reach);
                queue_event(n_before, open_event || $urandom_range(0, 3) != 0,
                            pick < 18, pick >= 18 && pick < 30);
                open_event = 0;
            end
        end
    endtask

    // Run limit
    initial begin
        #2_000_000;
        $display("trigger_block_time_width_extract regression: fail");
        $finish;
    end

    // Stimulus and end of run
    initial begin : stimulus
        int guard;
        restart_walk();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Early end on the very first header word
        push_word('1, 1'b1, 1'b1);
        // Event started without a start mark; scan block of length zero
        push_word('0, 1'b0, 1'b0);
        push_word('1, 1'b0, 1'b0);
        push_word('0, 1'b0, 1'b0);
        push_word({SEPARATOR, 32'h0}, 1'b0, 1'b1);
        // Bad separator in the first block header
        push_word('0, 1'b1, 1'b0);
        push_word('0, 1'b0, 1'b0);
        push_word('0, 1'b0, 1'b0);
        push_word({32'h0, 32'h7}, 1'b0, 1'b1);
        // One sample with the trigger firing in the low byte
        push_word('1, 1'b1, 1'b0);
        push_word('1, 1'b0, 1'b0);
        push_word('1, 1'b0, 1'b0);
        push_word({SEPARATOR, 32'h7}, 1'b0, 1'b0);
        repeat (BX_WORDS - 1) push_word('1, 1'b0, 1'b0);
        push_word(64'h0000_0000_0000_00ff, 1'b0, 1'b1);
        // All-ones sample
        push_word('0, 1'b1, 1'b0);
        push_word('1, 1'b0, 1'b0);
        push_word('0, 1'b0, 1'b0);
        push_word({SEPARATOR, 24'hffffff, 8'h7}, 1'b0, 1'b0);
        repeat (BX_WORDS - 1) push_word('0, 1'b0, 1'b0);
        push_word('1, 1'b0, 1'b1);

        run_setting(0, LIMIT_RESET, SCINT_RESET, 400);
        run_setting(1, 8'd0,   8'd0,   120);
        run_setting(1, 8'd255, 8'd255, 300);
        run_setting(1, 8'd4,   8'd2,   180);
        run_setting(1, 8'd3,   8'd1,   150);
        run_setting(1, 8'd255, 8'd0,   150);
        run_setting(1, 8'd2,   8'd5,   120);
        run_setting(1, 8'd8,   8'd3,   150);
        run_setting(1, 8'd1,   8'd0,   100);

        guard = 0;
        while ((pending_words.size() != 0 || i_in_valid || want_results.size() != 0)
               && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        if (want_results.size() != 0)
            report_mismatch("results never returned", want_results.size(), 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("trigger_block_time_width_extract regression: pass");
        end else begin
            $display("trigger_block_time_width_extract regression: fail");
        end
        $finish;
    end

endmodule

[files.f]
sv/tbtw_pkg.sv
sv/tbtw_lzc.sv
sv/trigger_block_time_width_extract.sv
sv/tbtw_checker.sv
tb/sv/trigger_block_time_width_extract_test.sv
